// ===== src/mrj_pkg.sv =====
// ----------------------------------------------------------------------------
// mrj_pkg
// Types and constants shared by the mailbox ring blocks.
// ----------------------------------------------------------------------------
package mrj_pkg;

  localparam int CAP_W = 5;
  localparam int SUM_W = CAP_W + 1;
  localparam int MSG_W = 32;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    OP_SEND = 2'd0,
    OP_JAM  = 2'd1,
    OP_RECV = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_INVALID = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]       operation;
    logic [MSG_W-1:0] message_in;
  } in_word_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [MSG_W-1:0] message_out;
    logic [CAP_W-1:0] fill_count;
  } out_word_t;

  typedef struct packed {
    status_t          status;
    logic             take;
    logic [CAP_W-1:0] fill;
  } ring_res_t;

endpackage

// ===== src/mrj_ram.sv =====
// ----------------------------------------------------------------------------
// mrj_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mrj_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/mrj_ring_ctrl.sv =====
// ----------------------------------------------------------------------------
// mrj_ring_ctrl
// Ring pointers, capacity register and per-word status and slot selection.
// ----------------------------------------------------------------------------
module mrj_ring_ctrl #(
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       go,
  input  mrj_pkg::op_t                               op,
  input  logic                                       cfg_we,
  input  logic [mrj_pkg::CAP_W-1:0]                  cfg_data,
  output mrj_pkg::ring_res_t                         res,
  output logic                                       wr_en,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  output logic                                       rd_en,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned DEPTH_U = DEPTH;

  logic [mrj_pkg::CAP_W-1:0] capacity;
  logic [mrj_pkg::CAP_W-1:0] head;
  logic [mrj_pkg::CAP_W-1:0] head_next;
  logic [mrj_pkg::CAP_W-1:0] held;
  logic [mrj_pkg::CAP_W-1:0] held_next;
  logic [mrj_pkg::CAP_W-1:0] slot;
  logic [mrj_pkg::CAP_W-1:0] tail;
  logic [mrj_pkg::CAP_W-1:0] jam_head;
  logic [mrj_pkg::CAP_W-1:0] recv_head;
  logic [mrj_pkg::SUM_W-1:0] cap_x;
  logic [mrj_pkg::SUM_W-1:0] sum_tail;
  logic [mrj_pkg::SUM_W-1:0] sum_jam;
  logic [mrj_pkg::SUM_W-1:0] sum_recv;
  logic                      cap_ok;
  logic                      do_write;
  mrj_pkg::status_t          status;

  // index wrap by compare and subtract
  always_comb begin
    cap_x    = {1'b0, capacity};
    sum_tail = {1'b0, head} + {1'b0, held};
    sum_jam  = {1'b0, head} + cap_x - mrj_pkg::SUM_W'(1);
    sum_recv = {1'b0, head} + mrj_pkg::SUM_W'(1);
    tail      = mrj_pkg::CAP_W'((sum_tail >= cap_x) ? (sum_tail - cap_x) : sum_tail);
    jam_head  = mrj_pkg::CAP_W'((sum_jam >= cap_x) ? (sum_jam - cap_x) : sum_jam);
    recv_head = mrj_pkg::CAP_W'((sum_recv >= cap_x) ? (sum_recv - cap_x) : sum_recv);
    cap_ok    = (capacity != '0) && (32'(capacity) <= DEPTH_U);
  end

  always_comb begin
    head_next = head;
    held_next = held;
    status    = mrj_pkg::ST_OK;
    do_write  = 1'b0;
    slot      = head;
    case (op)
      mrj_pkg::OP_SEND: begin
        if (!cap_ok) begin
          status = mrj_pkg::ST_INVALID;
        end else if (held >= capacity) begin
          status = mrj_pkg::ST_FULL;
        end else begin
          do_write  = 1'b1;
          slot      = tail;
          held_next = held + mrj_pkg::CAP_W'(1);
        end
      end
      mrj_pkg::OP_JAM: begin
        if (!cap_ok) begin
          status = mrj_pkg::ST_INVALID;
        end else if (held >= capacity) begin
          status = mrj_pkg::ST_FULL;
        end else begin
          do_write  = 1'b1;
          slot      = jam_head;
          head_next = jam_head;
          held_next = held + mrj_pkg::CAP_W'(1);
        end
      end
      mrj_pkg::OP_RECV: begin
        if (!cap_ok) begin
          status = mrj_pkg::ST_INVALID;
        end else if (held == '0) begin
          status = mrj_pkg::ST_EMPTY;
        end else begin
          head_next = recv_head;
          held_next = held - mrj_pkg::CAP_W'(1);
        end
      end
      default: begin
        status = mrj_pkg::ST_OK;
      end
    endcase
  end

  always_comb begin
    res.status = status;
    res.take   = (op == mrj_pkg::OP_RECV) && (status == mrj_pkg::ST_OK);
    res.fill   = held_next;
    wr_en      = go && do_write;
    wr_addr    = AW'(slot);
    rd_en      = go;
    rd_addr    = AW'(head);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= mrj_pkg::CAP_RESET;
      head     <= '0;
      held     <= '0;
    end else if (cfg_we) begin
      capacity <= cfg_data;
      head     <= '0;
      held     <= '0;
    end else if (go) begin
      head <= head_next;
      held <= held_next;
    end
  end

endmodule

// ===== src/mailbox_ring_with_jam.sv =====
// ----------------------------------------------------------------------------
// mailbox_ring_with_jam
// Ring mailbox of 32-bit messages with send at tail, jam at head and
// receive from head, capacity set by one configuration register.
// ----------------------------------------------------------------------------
//  port group   direction  handshake           word
//  in_*         input      in_valid/in_ready   operation, message_in
//  out_*        output     out_valid/out_ready status, message_out, fill_count
//  cfg_*        input      cfg_we              capacity
//
//  one word accepted per cycle while in_ready; result valid on the next cycle
//  ring pointers update when a word is taken, the slot read lands in the ram
//  output register, which holds the result stable while out_ready is low
//  in_ready is high while the result register is empty or being taken
//  reset gives capacity 16 and an empty ring; no clearing pass
// ----------------------------------------------------------------------------
module mailbox_ring_with_jam #(
  parameter int DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  mrj_pkg::in_word_t         in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output mrj_pkg::out_word_t        out_data,
  input  logic                      cfg_we,
  input  logic [mrj_pkg::CAP_W-1:0] cfg_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                      go;
  mrj_pkg::ring_res_t        res;
  mrj_pkg::ring_res_t        res_q;
  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  logic                      rd_en;
  logic [AW-1:0]             rd_addr;
  logic [mrj_pkg::MSG_W-1:0] rd_data;

  assign in_ready = !out_valid || out_ready;
  assign go       = in_valid && in_ready;

  mrj_ring_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .go      (go),
    .op      (mrj_pkg::op_t'(in_data.operation)),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .res     (res),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr)
  );

  mrj_ram #(
    .WIDTH(mrj_pkg::MSG_W),
    .DEPTH(DEPTH)
  ) u_slots (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(in_data.message_in),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      res_q <= res;
    end
  end

  always_comb begin
    out_data.status      = res_q.status;
    out_data.message_out = res_q.take ? rd_data : '0;
    out_data.fill_count  = res_q.fill;
  end

endmodule
